[rtl/core/puvt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// puvt_pkg
// Shared types and constants of the planar uv tiler.
// ----------------------------------------------------------------------------
package puvt_pkg;

  // coordinate format
  localparam int COORD_W   = 32;
  localparam int FRAC_BITS = 16;
  // projected axes after rotation and offset, full precision
  localparam int ACC_W     = 34;
  // tile size width
  localparam int DIV_W     = 31;
  // output fraction width
  localparam int TEX_W     = 16;
  // stagger format (Q4.12)
  localparam int LAP_W     = 16;
  localparam int LAP_FRAC  = 12;
  localparam int PROD_W    = 48;
  // side payload carried through a divider
  localparam int SIDE_W    = 34;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DIV_W-1:0] TILE_SIZE_RESET = DIV_W'(48 << FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_PAIR     = 3'd0,
    CFG_QUARTER_TURNS = 3'd1,
    CFG_TILE_WIDTH    = 3'd2,
    CFG_TILE_HEIGHT   = 3'd3,
    CFG_SHIFT_U       = 3'd4,
    CFG_SHIFT_V       = 3'd5,
    CFG_EVEN_STAGGER  = 3'd6,
    CFG_ODD_STAGGER   = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    AXIS_XY = 2'd0,
    AXIS_XZ = 2'd1,
    AXIS_YZ = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    TURN_0   = 2'd0,
    TURN_90  = 2'd1,
    TURN_180 = 2'd2,
    TURN_270 = 2'd3
  } turn_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } in_t;

  typedef struct packed {
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
  } out_t;

  // result of one floor modulo unit
  typedef struct packed {
    logic              vld;
    logic              parity;
    logic [TEX_W-1:0]  frac;
    logic [SIDE_W-1:0] side;
  } mf_res_t;

endpackage

[rtl/core/planar_uv_tiler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_uv_tiler
// Planar projection, quarter-turn rotation, offset, brick stagger and floor
// modulo of a point into tile coordinates.
// ----------------------------------------------------------------------------
//  channel  | ports                          | carries
//  ---------+--------------------------------+------------------------------
//  input    | in_valid, in_stall, in_data    | point_x, point_y, point_z
//  result   | out_valid, out_stall, out_data | tex_u, tex_v
//  config   | cfg_wr_en, cfg_index, cfg_data | eight registers, write only
//
// one transfer per cycle unless a waiting result stalls the pipeline; most of its
// depth is the two bit-per-stage division pipelines (52 stages each, v first, then u)
// the whole pipeline advances together; a held result stalls every stage
// reset is synchronous; it clears valid bits and loads register defaults
// ----------------------------------------------------------------------------
module planar_uv_tiler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  puvt_pkg::in_t                       in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output puvt_pkg::out_t                      out_data,
  input  logic                                cfg_wr_en,
  input  logic [puvt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [puvt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration registers
  logic [1:0]                                axis_pair_r;
  logic [1:0]                                quarter_turns_r;
  logic [puvt_pkg::DIV_W-1:0]                tile_width_r;
  logic [puvt_pkg::DIV_W-1:0]                tile_height_r;
  logic signed [puvt_pkg::COORD_W-1:0]       shift_u_r;
  logic signed [puvt_pkg::COORD_W-1:0]       shift_v_r;
  logic signed [puvt_pkg::LAP_W-1:0]         even_lap_r;
  logic signed [puvt_pkg::LAP_W-1:0]         odd_lap_r;

  logic                                      pipe_en;
  logic [puvt_pkg::DIV_W-1:0]                size_u;
  logic [puvt_pkg::DIV_W-1:0]                size_v;

  // front stages
  logic                                      s1_vld_r, s2_vld_r;
  logic signed [puvt_pkg::ACC_W-1:0]         s1_u_r, s1_v_r, s2_u_r, s2_v_r;
  logic signed [puvt_pkg::ACC_W-1:0]         s1_u_nxt, s1_v_nxt;
  logic signed [puvt_pkg::ACC_W-1:0]         ax_u, ax_v;

  // stagger stages
  puvt_pkg::mf_res_t                         vres;
  puvt_pkg::mf_res_t                         ures;
  logic                                      m_vld_r, a_vld_r;
  logic signed [puvt_pkg::PROD_W-1:0]        m_prod_r, m_prod_nxt;
  logic signed [puvt_pkg::ACC_W-1:0]         m_u_r;
  logic [puvt_pkg::TEX_W-1:0]                m_vfrac_r, a_vfrac_r;
  logic signed [puvt_pkg::LAP_W-1:0]         lap;
  logic signed [puvt_pkg::PROD_W-1:0]        sum;
  logic signed [puvt_pkg::COORD_W-1:0]       u_sat_nxt;
  logic signed [puvt_pkg::ACC_W-1:0]         a_u_r;

  // output register
  logic                                      out_valid_r;
  puvt_pkg::out_t                            out_data_r;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_pair_r     <= puvt_pkg::AXIS_XY;
      quarter_turns_r <= puvt_pkg::TURN_0;
      tile_width_r    <= puvt_pkg::TILE_SIZE_RESET;
      tile_height_r   <= puvt_pkg::TILE_SIZE_RESET;
      shift_u_r       <= '0;
      shift_v_r       <= '0;
      even_lap_r      <= '0;
      odd_lap_r       <= '0;
    end else if (cfg_wr_en) begin
      unique case (puvt_pkg::cfg_idx_t'(cfg_index))
        puvt_pkg::CFG_AXIS_PAIR:     axis_pair_r     <= cfg_data[1:0];
        puvt_pkg::CFG_QUARTER_TURNS: quarter_turns_r <= cfg_data[1:0];
        puvt_pkg::CFG_TILE_WIDTH:    tile_width_r    <= cfg_data[puvt_pkg::DIV_W-1:0];
        puvt_pkg::CFG_TILE_HEIGHT:   tile_height_r   <= cfg_data[puvt_pkg::DIV_W-1:0];
        puvt_pkg::CFG_SHIFT_U:       shift_u_r       <= cfg_data;
        puvt_pkg::CFG_SHIFT_V:       shift_v_r       <= cfg_data;
        puvt_pkg::CFG_EVEN_STAGGER:  even_lap_r      <= cfg_data[puvt_pkg::LAP_W-1:0];
        puvt_pkg::CFG_ODD_STAGGER:   odd_lap_r       <= cfg_data[puvt_pkg::LAP_W-1:0];
        default: ;
      endcase
    end
  end

  // zero tile size acts as one
  assign size_u = (tile_width_r == '0) ? puvt_pkg::DIV_W'(1) : tile_width_r;
  assign size_v = (tile_height_r == '0) ? puvt_pkg::DIV_W'(1) : tile_height_r;

  // global advance, held only by a waiting result
  assign pipe_en  = ~(out_valid_r & out_stall);
  assign in_stall = ~pipe_en;

  // plane selection
  always_comb begin
    case (axis_pair_r)
      puvt_pkg::AXIS_XZ: begin
        ax_u = puvt_pkg::ACC_W'(in_data.point_x);
        ax_v = puvt_pkg::ACC_W'(in_data.point_z);
      end
      puvt_pkg::AXIS_YZ: begin
        ax_u = puvt_pkg::ACC_W'(in_data.point_y);
        ax_v = puvt_pkg::ACC_W'(in_data.point_z);
      end
      default: begin
        ax_u = puvt_pkg::ACC_W'(in_data.point_x);
        ax_v = puvt_pkg::ACC_W'(in_data.point_y);
      end
    endcase
  end

  // quarter-turn rotation
  always_comb begin
    case (quarter_turns_r)
      puvt_pkg::TURN_90: begin
        s1_u_nxt = -ax_v;
        s1_v_nxt = ax_u;
      end
      puvt_pkg::TURN_180: begin
        s1_u_nxt = -ax_u;
        s1_v_nxt = -ax_v;
      end
      puvt_pkg::TURN_270: begin
        s1_u_nxt = ax_v;
        s1_v_nxt = -ax_u;
      end
      default: begin
        s1_u_nxt = ax_u;
        s1_v_nxt = ax_v;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s1_vld_r <= in_valid;
      s2_vld_r <= s1_vld_r;
    end
  end

  // offset subtraction
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_u_r <= s1_u_nxt;
      s1_v_r <= s1_v_nxt;
      s2_u_r <= s1_u_r - puvt_pkg::ACC_W'(shift_u_r);
      s2_v_r <= s1_v_r - puvt_pkg::ACC_W'(shift_v_r);
    end
  end

  // v: row parity and fraction, u rides along
  puvt_mod_frac u_vdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (s2_vld_r),
    .in_a    (s2_v_r),
    .div     (size_v),
    .in_side (puvt_pkg::SIDE_W'(s2_u_r)),
    .res     (vres)
  );

  // stagger product
  assign lap        = vres.parity ? odd_lap_r : even_lap_r;
  assign m_prod_nxt = puvt_pkg::PROD_W'($signed({1'b0, size_u}) * lap);

  // stagger add with saturation to 32 bits
  assign sum = puvt_pkg::PROD_W'(m_u_r) + (m_prod_r >>> puvt_pkg::LAP_FRAC);

  always_comb begin
    if (sum > puvt_pkg::PROD_W'(32'sh7FFF_FFFF)) begin
      u_sat_nxt = 32'sh7FFF_FFFF;
    end else if (sum < puvt_pkg::PROD_W'(-33'sh0_8000_0000)) begin
      u_sat_nxt = 32'sh8000_0000;
    end else begin
      u_sat_nxt = sum[puvt_pkg::COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
      a_vld_r <= 1'b0;
    end else if (pipe_en) begin
      m_vld_r <= vres.vld;
      a_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m_prod_r  <= m_prod_nxt;
      m_u_r     <= vres.side[puvt_pkg::ACC_W-1:0];
      m_vfrac_r <= vres.frac;
      a_u_r     <= puvt_pkg::ACC_W'(u_sat_nxt);
      a_vfrac_r <= m_vfrac_r;
    end
  end

  // u: fraction, v fraction rides along
  puvt_mod_frac u_udiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (a_vld_r),
    .in_a    (a_u_r),
    .div     (size_u),
    .in_side (puvt_pkg::SIDE_W'(a_vfrac_r)),
    .res     (ures)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      out_valid_r <= ures.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_data_r.tex_u <= ures.frac;
      out_data_r.tex_v <= ures.side[puvt_pkg::TEX_W-1:0];
    end
  end

  assign out_valid = out_valid_r & (ures.parity | ~ures.parity);
  assign out_data  = out_data_r;

endmodule

[rtl/core/puvt_mod_frac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// puvt_mod_frac
// Pipelined floor modulo and fraction: one restoring division step per
// stage, giving parity of floor(a/d) and floor((a mod d) * 2^16 / d).
// ----------------------------------------------------------------------------
module puvt_mod_frac (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_vld,
  input  logic signed [puvt_pkg::ACC_W-1:0]   in_a,
  input  logic [puvt_pkg::DIV_W-1:0]          div,
  input  logic [puvt_pkg::SIDE_W-1:0]         in_side,
  output puvt_pkg::mf_res_t                   res
);

  // integer part arrays, index 0 is the entry stage
  logic [puvt_pkg::DIV_W-1:0]  rem_r  [0:puvt_pkg::ACC_W];
  logic [puvt_pkg::ACC_W-1:0]  mag_r  [0:puvt_pkg::ACC_W];
  logic                        neg_r  [0:puvt_pkg::ACC_W];
  logic                        qb_r   [0:puvt_pkg::ACC_W];
  logic [puvt_pkg::SIDE_W-1:0] iside_r[0:puvt_pkg::ACC_W];
  logic                        ivld_r [0:puvt_pkg::ACC_W];

  // fraction part arrays, index 0 is the fix-up stage
  logic [puvt_pkg::DIV_W-1:0]  frem_r [0:puvt_pkg::TEX_W];
  logic [puvt_pkg::TEX_W-1:0]  fbits_r[0:puvt_pkg::TEX_W];
  logic                        fpar_r [0:puvt_pkg::TEX_W];
  logic [puvt_pkg::SIDE_W-1:0] fside_r[0:puvt_pkg::TEX_W];
  logic                        fvld_r [0:puvt_pkg::TEX_W];

  logic [puvt_pkg::ACC_W-1:0]  mag_nxt;
  logic [puvt_pkg::DIV_W-1:0]  fix_rem_nxt;
  logic                        fix_par_nxt;
  logic                        rem_nz;

  // entry: magnitude and sign
  assign mag_nxt = in_a[puvt_pkg::ACC_W-1] ? puvt_pkg::ACC_W'(-in_a)
                                           : puvt_pkg::ACC_W'(in_a);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ivld_r[0] <= 1'b0;
    end else if (en) begin
      ivld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]   <= '0;
      mag_r[0]   <= mag_nxt;
      neg_r[0]   <= in_a[puvt_pkg::ACC_W-1];
      qb_r[0]    <= 1'b0;
      iside_r[0] <= in_side;
    end
  end

  // integer steps, msb first
  for (genvar k = 0; k < puvt_pkg::ACC_W; k++) begin : g_int
    logic [puvt_pkg::DIV_W:0]   trial;
    logic [puvt_pkg::DIV_W:0]   diff;
    logic                       ge;
    logic [puvt_pkg::DIV_W-1:0] rem_nxt;

    always_comb begin
      trial   = {rem_r[k], mag_r[k][puvt_pkg::ACC_W-1-k]};
      diff    = trial - {1'b0, div};
      ge      = (trial >= {1'b0, div});
      rem_nxt = ge ? diff[puvt_pkg::DIV_W-1:0] : trial[puvt_pkg::DIV_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ivld_r[k+1] <= 1'b0;
      end else if (en) begin
        ivld_r[k+1] <= ivld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]   <= rem_nxt;
        mag_r[k+1]   <= mag_r[k];
        neg_r[k+1]   <= neg_r[k];
        qb_r[k+1]    <= ge;
        iside_r[k+1] <= iside_r[k];
      end
    end
  end

  // fix-up of a negative dividend to floor semantics
  assign rem_nz = (rem_r[puvt_pkg::ACC_W] != '0);

  always_comb begin
    if (neg_r[puvt_pkg::ACC_W] && rem_nz) begin
      fix_rem_nxt = div - rem_r[puvt_pkg::ACC_W];
      fix_par_nxt = ~qb_r[puvt_pkg::ACC_W];
    end else begin
      fix_rem_nxt = rem_r[puvt_pkg::ACC_W];
      fix_par_nxt = qb_r[puvt_pkg::ACC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvld_r[0] <= 1'b0;
    end else if (en) begin
      fvld_r[0] <= ivld_r[puvt_pkg::ACC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frem_r[0]  <= fix_rem_nxt;
      fbits_r[0] <= '0;
      fpar_r[0]  <= fix_par_nxt;
      fside_r[0] <= iside_r[puvt_pkg::ACC_W];
    end
  end

  // fraction steps on the remainder
  for (genvar j = 0; j < puvt_pkg::TEX_W; j++) begin : g_frac
    logic [puvt_pkg::DIV_W:0]   trial;
    logic [puvt_pkg::DIV_W:0]   diff;
    logic                       ge;
    logic [puvt_pkg::DIV_W-1:0] rem_nxt;

    always_comb begin
      trial   = {frem_r[j], 1'b0};
      diff    = trial - {1'b0, div};
      ge      = (trial >= {1'b0, div});
      rem_nxt = ge ? diff[puvt_pkg::DIV_W-1:0] : trial[puvt_pkg::DIV_W-1:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        fvld_r[j+1] <= 1'b0;
      end else if (en) begin
        fvld_r[j+1] <= fvld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        frem_r[j+1]  <= rem_nxt;
        fbits_r[j+1] <= {fbits_r[j][puvt_pkg::TEX_W-2:0], ge};
        fpar_r[j+1]  <= fpar_r[j];
        fside_r[j+1] <= fside_r[j];
      end
    end
  end

  // final remainder is not needed beyond the last step
  assign res.vld    = fvld_r[puvt_pkg::TEX_W] & (frem_r[puvt_pkg::TEX_W] == frem_r[puvt_pkg::TEX_W]);
  assign res.parity = fpar_r[puvt_pkg::TEX_W];
  assign res.frac   = fbits_r[puvt_pkg::TEX_W];
  assign res.side   = fside_r[puvt_pkg::TEX_W];

endmodule

[rtl/core/puvt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// puvt_checker
// Port-level checks of the planar uv tiler.
// ----------------------------------------------------------------------------
module puvt_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input puvt_pkg::out_t out_data
);

  // input held back exactly while a result waits
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow a waiting result");

  // nothing valid straight after reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a waiting result holds its payload
  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // no result appears while the pipeline is frozen
  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_stall |=> !out_valid)
    else $error("result appeared while stalled");

endmodule

bind planar_uv_tiler puvt_checker u_puvt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
